// ===== design/mms_pkg.sv =====
// Shared constants and control types for the moving mean-square core.
package mms_pkg;

    localparam int DEF_MAX_WINDOW   = 256;
    localparam int DEF_SAMPLE_WIDTH = 16;
    localparam int CFG_W            = 9;
    localparam int OUT_W            = 31;
    localparam int RESET_LEN        = 2;

    typedef struct packed {
        logic cfg_write;
        logic accept;
        logic sq_new;
        logic sq_old;
        logic acc;
        logic upd;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_last;
    } t_status;

endpackage

// ===== design/moving_mean_square_core.sv =====
// Top level of the moving mean-square core: controller and datapath.
//
// Channel      Direction  Handshake             Payload
// config       in         i_cfg_valid/o_cfg_ready i_window_length[8:0]
// sample       in         i_sample_valid/o_sample_stall i_sample[SAMPLE_WIDTH-1:0]
// mean_square  out        o_mean_square_valid/i_mean_square_stall o_mean_square[30:0]
//
// A new sample is not taken until the previous one has finished; o_sample_stall stays high meanwhile.
// The division is done by the restoring divider, which retires one quotient bit a cycle.
// A finished result sits in the output register while the next sample is taken.
// Reset is synchronous; the sample ring needs no clearing pass after reset or a write.
// A configuration request is taken only while no sample is in progress and holds off
// a sample request offered in the same cycle.
module moving_mean_square_core
    import mms_pkg::*;
#(
    parameter int MAX_WINDOW   = DEF_MAX_WINDOW,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_W-1:0]        i_window_length,
    input  logic                    i_sample_valid,
    output logic                    o_sample_stall,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    output logic                    o_mean_square_valid,
    input  logic                    i_mean_square_stall,
    output logic [OUT_W-1:0]        o_mean_square
);

    t_cmd    cmd;
    t_status status;

    mms_ctrl u_ctrl (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_sample_valid      (i_sample_valid),
        .o_sample_stall      (o_sample_stall),
        .o_mean_square_valid (o_mean_square_valid),
        .i_mean_square_stall (i_mean_square_stall),
        .i_status            (status),
        .o_cmd               (cmd)
    );

    mms_dpath #(
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_window_length (i_window_length),
        .i_sample        (i_sample),
        .o_mean_square   (o_mean_square)
    );

endmodule

// ===== design/mms_ctrl.sv =====
// Sequencing state machine and handshakes for the moving mean-square core.
module mms_ctrl
    import mms_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_valid,
    output logic    o_cfg_ready,
    input  logic    i_sample_valid,
    output logic    o_sample_stall,
    output logic    o_mean_square_valid,
    input  logic    i_mean_square_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_NEW,
        ST_SQ_OLD,
        ST_ACC,
        ST_UPD,
        ST_DIV,
        ST_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free            = !r_out_valid || !i_mean_square_stall;
    assign o_cfg_ready         = (r_state == ST_IDLE);
    assign o_sample_stall      = (r_state != ST_IDLE) || i_cfg_valid;
    assign o_mean_square_valid = r_out_valid;

    always_comb begin
        o_cmd           = '0;
        n_state         = r_state;
        n_out_valid     = r_out_valid && i_mean_square_stall;
        o_cmd.cfg_write = i_cfg_valid && (r_state == ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_sample_valid && !i_cfg_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_SQ_NEW;
                end
            end
            ST_SQ_NEW: begin
                o_cmd.sq_new = 1'b1;
                n_state      = ST_SQ_OLD;
            end
            ST_SQ_OLD: begin
                o_cmd.sq_old = 1'b1;
                n_state      = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = ST_UPD;
            end
            ST_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== design/mms_dpath.sv =====
// Sample ring, shared squarer, running sum and restoring divider.
module mms_dpath
    import mms_pkg::*;
#(
    parameter int MAX_WINDOW   = DEF_MAX_WINDOW,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    input  logic [CFG_W-1:0]        i_window_length,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    output logic [OUT_W-1:0]        o_mean_square
);

    localparam int DEPTH = MAX_WINDOW - 1;
    localparam int IDX_W = (MAX_WINDOW > 2) ? $clog2(MAX_WINDOW - 1) : 1;
    localparam int LEN_W = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;
    localparam int SQ_W  = 2 * SAMPLE_WIDTH;
    localparam int SUM_W = 2 * SAMPLE_WIDTH - 1 + $clog2(MAX_WINDOW);
    localparam int CNT_W = $clog2(SUM_W);
    localparam int EXT_W = (SUM_W > OUT_W) ? SUM_W : OUT_W;

    logic [SAMPLE_WIDTH-1:0] r_ring [DEPTH];
    logic [SAMPLE_WIDTH-1:0] r_sample;
    logic [SAMPLE_WIDTH-1:0] r_rd;
    logic [LEN_W-1:0]        r_len;
    logic [IDX_W-1:0]        r_pos;
    logic                    r_wrapped;
    logic [SUM_W-1:0]        r_sum;
    logic [SQ_W-1:0]         r_sq_new;
    logic [SQ_W-1:0]         r_sq_old;
    logic [SUM_W-1:0]        r_quo;
    logic [LEN_W-1:0]        r_rem;
    logic [CNT_W-1:0]        r_cnt;
    logic [OUT_W-1:0]        r_out;

    logic [SAMPLE_WIDTH-1:0] old_val;
    logic [SAMPLE_WIDTH-1:0] mul_in;
    logic [SAMPLE_WIDTH-1:0] mag;
    logic [SQ_W-1:0]         prod;
    logic [CMP_W-1:0]        wl_cmp;
    logic [CMP_W-1:0]        len_sat;
    logic [LEN_W-1:0]        pos_inc;
    logic [LEN_W:0]          rem_sh;
    logic [LEN_W:0]          len_ext;
    logic                    ge;
    logic [LEN_W:0]          rem_next;
    logic [EXT_W-1:0]        quo_ext;

    assign old_val = r_wrapped ? r_rd : '0;
    assign mul_in  = i_cmd.sq_old ? old_val : r_sample;
    assign mag     = mul_in[SAMPLE_WIDTH-1] ? (~mul_in + 1'b1) : mul_in;
    assign prod    = SQ_W'(mag) * SQ_W'(mag);

    assign wl_cmp  = CMP_W'(i_window_length);
    always_comb begin
        if (wl_cmp < CMP_W'(2)) begin
            len_sat = CMP_W'(2);
        end else if (wl_cmp > CMP_W'(MAX_WINDOW)) begin
            len_sat = CMP_W'(MAX_WINDOW);
        end else begin
            len_sat = wl_cmp;
        end
    end

    assign pos_inc  = LEN_W'(r_pos) + LEN_W'(1);
    assign rem_sh   = {r_rem, r_quo[SUM_W-1]};
    assign len_ext  = (LEN_W + 1)'(r_len);
    assign ge       = (rem_sh >= len_ext);
    assign rem_next = ge ? (rem_sh - len_ext) : rem_sh;
    assign quo_ext  = EXT_W'(r_quo);

    assign o_status.div_last = (r_cnt == '0);
    assign o_mean_square     = r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd <= r_ring[r_pos];
        end
        if (i_cmd.upd) begin
            r_ring[r_pos] <= r_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= LEN_W'(RESET_LEN);
            r_pos     <= '0;
            r_wrapped <= 1'b0;
            r_sum     <= '0;
            r_cnt     <= '0;
        end else begin
            if (i_cmd.cfg_write) begin
                r_len     <= LEN_W'(len_sat);
                r_pos     <= '0;
                r_wrapped <= 1'b0;
                r_sum     <= '0;
            end
            if (i_cmd.acc) begin
                r_cnt <= CNT_W'(SUM_W - 1);
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt - 1'b1;
            end
            if (i_cmd.upd) begin
                r_sum <= r_quo - SUM_W'(r_sq_old);
                if (pos_inc >= r_len - LEN_W'(1)) begin
                    r_pos     <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_pos <= r_pos + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_sample;
        end
        if (i_cmd.sq_new) begin
            r_sq_new <= prod;
        end
        if (i_cmd.sq_old) begin
            r_sq_old <= prod;
        end
        if (i_cmd.acc) begin
            r_quo <= r_sum + SUM_W'(r_sq_new);
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[SUM_W-2:0], ge};
            r_rem <= rem_next[LEN_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_out <= quo_ext[OUT_W-1:0];
        end
    end

endmodule
